@@ rtl/eftp_pkg.sv @@
// ----------------------------------------------------------------------------
// eftp_pkg
// Shared constants and types of the ergometer telemetry frame parser.
// ----------------------------------------------------------------------------
package eftp_pkg;

  localparam int unsigned WinLen   = 19;
  localparam int unsigned FillW    = $clog2(WinLen + 1);
  localparam int unsigned ByteW    = 8;

  localparam logic [ByteW-1:0] SyncTelemA = 8'h40;
  localparam logic [ByteW-1:0] SyncTelemB = 8'h41;

  localparam int unsigned PowerW = 11;
  localparam int unsigned DistW  = 23;

  localparam int unsigned OffsAddr    = 1;
  localparam int unsigned OffsPower   = 5;
  localparam int unsigned OffsCadence = 6;
  localparam int unsigned OffsSpeed   = 7;
  localparam int unsigned OffsDistLo  = 8;
  localparam int unsigned OffsDistHi  = 9;
  localparam int unsigned OffsHeart   = 14;
  localparam int unsigned OffsGear    = 16;

  localparam int unsigned OutPayloadW = PowerW + 4 * ByteW + DistW;
  localparam int unsigned OutTdataW   = ((OutPayloadW + 7) / 8) * 8;
  localparam int unsigned OutTuserW   = 2;

  typedef struct packed {
    logic [ByteW-1:0]  gear_number;
    logic [ByteW-1:0]  heart_rate_bpm;
    logic [DistW-1:0]  distance_meters;
    logic [ByteW-1:0]  speed_kmh;
    logic [ByteW-1:0]  cadence_rpm;
    logic [PowerW-1:0] power_watts;
  } telem_t;

  typedef struct packed {
    logic response_empty;
    logic frame_found;
  } status_t;

endpackage

@@ rtl/ergometer_telemetry_frame_parser.sv @@
// ----------------------------------------------------------------------------
// ergometer_telemetry_frame_parser
// Finds the telemetry frame in a cockpit response and decodes its fields.
// ----------------------------------------------------------------------------
// Bytes of one response enter on the s_axis channel, one per request, with
// tlast on the final byte. A 19-byte shift window holds the tail of the
// current response. The first full window that starts with 0x40 or 0x41 and
// carries cockpit_address in its second byte yields one telemetry result on
// m_axis (tuser frame_found = 1); later bytes of that response are dropped.
// A response that ends without a frame yields one failure result with all
// telemetry fields zero. cockpit_address is written on the cfg channel,
// which is always ready; write it only while the block is idle.
// The result is registered: it appears on m_axis in the cycle after the byte
// that causes it. One byte per cycle is accepted while no result is stalled.
// When the receiver stalls with a result pending, s_axis_tready drops until
// the result is taken; in the cycle it is taken a new byte is accepted.
// Reset clears the address, the fill count and the response flags and
// empties the output register; window contents are not cleared.
// ----------------------------------------------------------------------------
module ergometer_telemetry_frame_parser
  import eftp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [ByteW-1:0]     cfg_data_i,     // cockpit_address
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [ByteW-1:0]     s_axis_tdata,   // rx_byte
  input  logic                 s_axis_tlast,   // last_of_response
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // power_watts, cadence_rpm, speed_kmh, distance_meters, heart_rate_bpm,
  // gear_number, zero fill
  output logic [OutTdataW-1:0] m_axis_tdata,
  output logic [OutTuserW-1:0] m_axis_tuser    // frame_found, response_empty
);

  logic [ByteW-1:0] addr_q;
  logic [ByteW-1:0] win_q [WinLen];
  logic [ByteW-1:0] win_d [WinLen];
  logic [FillW-1:0] fill_q, fill_d, fill_next;
  logic             frame_seen_q, frame_seen_d;
  logic             bytes_seen_q, bytes_seen_d;
  logic             out_valid_q;
  telem_t           telem_q, telem_d;
  status_t          status_q, status_d;

  logic             in_acc;
  logic             shift;
  logic             hit;
  logic             fail;
  logic             bytes_now;
  logic [15:0]      dist_count;
  logic [DistW-1:0] dist_ext;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign shift         = !frame_seen_q;

  always_comb begin
    for (int i = 0; i < WinLen - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[WinLen-1] = s_axis_tdata;
  end

  always_comb begin
    fill_next = fill_q;
    if (shift && (fill_q != FillW'(WinLen))) begin
      fill_next = fill_q + 1'b1;
    end
  end

  assign hit = shift && (fill_next == FillW'(WinLen))
            && ((win_d[0] == SyncTelemA) || (win_d[0] == SyncTelemB))
            && (win_d[OffsAddr] == addr_q);
  assign fail      = s_axis_tlast && !frame_seen_q && !hit;
  assign bytes_now = bytes_seen_q || shift;

  assign dist_count = {win_d[OffsDistHi], win_d[OffsDistLo]};
  assign dist_ext   = DistW'(dist_count);

  always_comb begin
    telem_d = '0;
    if (hit) begin
      telem_d.cadence_rpm     = win_d[OffsCadence];
      telem_d.speed_kmh       = win_d[OffsSpeed];
      telem_d.heart_rate_bpm  = win_d[OffsHeart];
      telem_d.gear_number     = win_d[OffsGear];
      telem_d.distance_meters = (dist_ext << 6) + (dist_ext << 5) + (dist_ext << 2);
      if (win_d[OffsCadence] != '0) begin
        telem_d.power_watts = (PowerW'(win_d[OffsPower]) << 2)
                            + PowerW'(win_d[OffsPower]);
      end
    end
    status_d.frame_found    = hit;
    status_d.response_empty = fail && !bytes_now;
  end

  always_comb begin
    frame_seen_d = frame_seen_q || hit;
    bytes_seen_d = bytes_now;
    fill_d       = fill_next;
    if (s_axis_tlast) begin
      frame_seen_d = 1'b0;
      bytes_seen_d = 1'b0;
      fill_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q       <= '0;
      fill_q       <= '0;
      frame_seen_q <= 1'b0;
      bytes_seen_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        addr_q <= cfg_data_i;
      end
      if (in_acc) begin
        fill_q       <= fill_d;
        frame_seen_q <= frame_seen_d;
        bytes_seen_q <= bytes_seen_d;
      end
      if (in_acc && (hit || fail)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && shift) begin
      win_q <= win_d;
    end
    if (in_acc && (hit || fail)) begin
      telem_q  <= telem_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdataW'(telem_q);
  assign m_axis_tuser  = status_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(WinLen))
    else $error("window fill count beyond window length");

  a_seen_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_seen_q |-> (fill_q == FillW'(WinLen)))
    else $error("frame marked seen without a full window");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> ((fill_q == '0) && !frame_seen_q && !bytes_seen_q))
    else $error("response state not cleared after final byte");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !status_q.frame_found) |-> (telem_q == '0))
    else $error("failure result carries telemetry");

  a_power_cad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (telem_q.power_watts != '0)) |-> (telem_q.cadence_rpm != '0))
    else $error("power reported with zero cadence");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ergometer telemetry frame parser.
// ----------------------------------------------------------------------------
// Streams cockpit responses into s_axis: clean frames with random content,
// frames with a bad sync byte or address, short responses and line noise.
// The cockpit address is rewritten between phases while the parser is idle.
// A shadow window tracks every accepted byte and queues the expected telemetry
// or failure result. Each result on m_axis is checked against it. The sender
// bursts and pauses, and the receiver stalls in several patterns, including
// one long hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb;
  import eftp_pkg::*;

  localparam int unsigned PowerScale   = 5;
  localparam int unsigned DistScale    = 100;
  localparam int unsigned PhaseBytes   = 66;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldAfter    = 150;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned MaxReports   = 10;

  localparam logic [ByteW-1:0] FixedAddr [4] = '{8'hFF, 8'h00, 8'h41, 8'h40};

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } rx_request_t;

  typedef struct packed {
    logic              found;
    logic              empty;
    logic [PowerW-1:0] power;
    logic [ByteW-1:0]  cadence;
    logic [ByteW-1:0]  speed;
    logic [DistW-1:0]  distance;
    logic [ByteW-1:0]  heart;
    logic [ByteW-1:0]  gear;
  } telemetry_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [ByteW-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ByteW-1:0]     s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic [OutTuserW-1:0] m_axis_tuser;

  rx_request_t  pending_requests [$];
  telemetry_t   expected_results [$];
  rx_request_t  next_request;
  int unsigned  bytes_queued   = 0;
  int unsigned  bytes_accepted = 0;
  int unsigned  mismatches     = 0;
  logic         in_fire        = 1'b0;
  int unsigned  burst_left     = 0;
  int unsigned  gap_left       = 0;

  rx_mode_e     rx_mode        = RX_FREE;
  logic [31:0]  rx_cycle       = '0;
  logic         hold_active    = 1'b0;
  logic         hold_done      = 1'b0;
  int unsigned  hold_left      = 0;

  logic [ByteW-1:0] cockpit_addr   = '0;
  logic [ByteW-1:0] rx_window [WinLen];
  logic [FillW-1:0] rx_fill        = '0;
  logic             resp_framed    = 1'b0;
  logic             resp_has_bytes = 1'b0;

  ergometer_telemetry_frame_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic track_response(input logic [ByteW-1:0] b, input logic last);
    telemetry_t r;
    if (!resp_framed) begin
      for (int i = 0; i < WinLen - 1; i++) rx_window[i] = rx_window[i + 1];
      rx_window[WinLen - 1] = b;
      if (rx_fill < WinLen) rx_fill = rx_fill + 1'b1;
      resp_has_bytes = 1'b1;
      if (rx_fill == WinLen &&
          (rx_window[0] == SyncTelemA || rx_window[0] == SyncTelemB) &&
          rx_window[OffsAddr] == cockpit_addr) begin
        r          = '0;
        r.found    = 1'b1;
        r.cadence  = rx_window[OffsCadence];
        r.power    = (r.cadence == '0) ? '0 : rx_window[OffsPower] * PowerW'(PowerScale);
        r.speed    = rx_window[OffsSpeed];
        r.distance = {rx_window[OffsDistHi], rx_window[OffsDistLo]} * DistW'(DistScale);
        r.heart    = rx_window[OffsHeart];
        r.gear     = rx_window[OffsGear];
        resp_framed = 1'b1;
        expected_results.push_back(r);
      end
    end
    if (last) begin
      if (!resp_framed) begin
        r       = '0;
        r.empty = !resp_has_bytes;
        expected_results.push_back(r);
      end
      rx_fill        = '0;
      resp_framed    = 1'b0;
      resp_has_bytes = 1'b0;
    end
  endtask

  task automatic flag_mismatch(input string what, input telemetry_t want,
                               input telemetry_t got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("%s: exp found=%0d empty=%0d pwr=%0d cad=%0d spd=%0d dist=%0d hr=%0d gear=%0d",
               what, want.found, want.empty, want.power, want.cadence, want.speed,
               want.distance, want.heart, want.gear,
               "\n    got found=%0d empty=%0d pwr=%0d cad=%0d spd=%0d dist=%0d hr=%0d gear=%0d",
               got.found, got.empty, got.power, got.cadence, got.speed,
               got.distance, got.heart, got.gear);
  endtask

  task automatic check_result();
    telem_t     t;
    status_t    st;
    telemetry_t got;
    telemetry_t want;
    t            = m_axis_tdata[$bits(telem_t)-1:0];
    st           = m_axis_tuser;
    got.found    = st.frame_found;
    got.empty    = st.response_empty;
    got.power    = t.power_watts;
    got.cadence  = t.cadence_rpm;
    got.speed    = t.speed_kmh;
    got.distance = t.distance_meters;
    got.heart    = t.heart_rate_bpm;
    got.gear     = t.gear_number;
    if (expected_results.size() == 0) begin
      flag_mismatch("unexpected result", '0, got);
    end else begin
      want = expected_results.pop_front();
      if (got !== want) flag_mismatch("result mismatch", want, got);
    end
  endtask

  // Monitor: check results, then track accepted bytes.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) begin
        track_response(s_axis_tdata, s_axis_tlast);
        bytes_accepted++;
      end
    end
  end

  // Driver: hold a request until taken, then advance in bursts.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (pending_requests.size() != 0) begin
        next_request = pending_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_request.data;
        s_axis_tlast  <= next_request.last;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, once.
  always @(negedge clk_i) begin
    if (!hold_done && bytes_accepted >= HoldAfter) begin
      hold_active <= 1'b1;
      hold_done   <= 1'b1;
      hold_left   <= HoldCycles;
    end else if (hold_active) begin
      if (hold_left == 0) hold_active <= 1'b0;
      else hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[5:0] == '0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    if (hold_active) begin
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= (rx_cycle % 5 != 0);
      endcase
    end
  end

  function automatic logic [ByteW-1:0] pick_field();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return ByteW'($urandom);
    endcase
  endfunction

  function automatic logic [ByteW-1:0] noise_byte();
    case ($urandom_range(0, 5))
      0:       return SyncTelemA;
      1:       return SyncTelemB;
      2:       return cockpit_addr;
      default: return ByteW'($urandom);
    endcase
  endfunction

  task automatic queue_byte(input logic [ByteW-1:0] b, input logic last);
    rx_request_t req;
    req.data = b;
    req.last = last;
    pending_requests.push_back(req);
    bytes_queued++;
  endtask

  task automatic queue_noise(input int unsigned n, input logic end_here);
    for (int unsigned k = 0; k < n; k++) queue_byte(noise_byte(), end_here && k == n - 1);
  endtask

  task automatic queue_frame(input logic [ByteW-1:0] sync, input logic [ByteW-1:0] addr,
                             input logic random_body, input logic [ByteW-1:0] body,
                             input logic end_here);
    queue_byte(sync, 1'b0);
    queue_byte(addr, 1'b0);
    for (int unsigned k = 2; k < WinLen; k++)
      queue_byte(random_body ? pick_field() : body, end_here && k == WinLen - 1);
  endtask

  task automatic queue_random_response(output int unsigned counted);
    int unsigned      kind;
    int unsigned      lead;
    int unsigned      trail;
    logic [ByteW-1:0] sync;
    logic [ByteW-1:0] addr;
    kind = $urandom_range(0, 99);
    sync = $urandom_range(0, 1) ? SyncTelemB : SyncTelemA;
    addr = cockpit_addr;
    if (kind < 60) begin
      lead  = $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
      trail = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
      queue_noise(lead, 1'b0);
      queue_frame(sync, addr, 1'b1, '0, trail == 0);
      queue_noise(trail, 1'b1);
      counted = lead + WinLen;
    end else if (kind < 75) begin
      if ($urandom_range(0, 1)) begin
        do sync = ByteW'($urandom); while (sync == SyncTelemA || sync == SyncTelemB);
      end else begin
        addr = cockpit_addr ^ (8'h01 << $urandom_range(0, 7));
      end
      queue_frame(sync, addr, 1'b1, '0, 1'b1);
      counted = WinLen;
    end else begin
      lead = (kind < 90) ? $urandom_range(1, WinLen - 1) : $urandom_range(1, 40);
      queue_noise(lead, 1'b1);
      counted = lead;
    end
  endtask

  task automatic wait_idle();
    forever begin
      @(negedge clk_i);
      if (bytes_accepted == bytes_queued && expected_results.size() == 0) break;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_address(input logic [ByteW-1:0] a);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= a;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cockpit_addr = a;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned      phase_bytes;
    int unsigned      got_bytes;
    logic [ByteW-1:0] addr;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_frame(SyncTelemB, 8'h00, 1'b0, 8'hFF, 1'b1);
    wait_idle();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      addr = (p < 4) ? FixedAddr[p] : ByteW'($urandom);
      write_address(addr);
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) begin
        queue_random_response(got_bytes);
        phase_bytes += got_bytes;
      end
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/eftp_pkg.sv
rtl/ergometer_telemetry_frame_parser.sv
bench/tb.sv
